@@ hw/rtl/vfo_frequency_stepper_top_defines.svh @@
// ----------------------------------------------------------------------------
// VFO frequency stepper assertion macros
// Shared property macros for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef VFO_FREQUENCY_STEPPER_TOP_DEFINES_SVH
`define VFO_FREQUENCY_STEPPER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vfo_frequency_stepper: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vfo_frequency_stepper: next-cycle check failed");

`endif

@@ hw/rtl/vfs_pkg.sv @@
// ----------------------------------------------------------------------------
// VFO frequency stepper package
// Widths, band limits, action and register codes, and the config struct.
// ----------------------------------------------------------------------------
`default_nettype none

package vfs_pkg;

    localparam int FREQ_W = 27;
    localparam int STEP_W = 24;
    localparam int SUM_W  = FREQ_W + 1;

    typedef logic [FREQ_W-1:0] t_freq;
    typedef logic [STEP_W-1:0] t_step;

    // Frequencies in units of 10 Hz.
    localparam t_freq LOW_LIMIT   = 27'd1000000;
    localparam t_freq HIGH_LIMIT  = 27'd130000000;
    localparam t_freq BAND_A_LO   = 27'd10800000;
    localparam t_freq BAND_A_HI   = 27'd13600000;
    localparam t_freq BAND_B_LO   = 27'd14400000;
    localparam t_freq BAND_B_HI   = 27'd14600000;
    localparam t_freq BAND_C_LO   = 27'd43000000;
    localparam t_freq BAND_C_HI   = 27'd44000000;
    localparam t_freq DIAL0_RESET = 27'd43002500;
    localparam t_freq DIAL1_RESET = 27'd43502500;

    localparam t_step STEP_RESET  = 24'd1250;

    // Action codes; code three is unused and leaves the dial alone.
    localparam logic [1:0] ACT_STEP_UP   = 2'd0;
    localparam logic [1:0] ACT_STEP_DOWN = 2'd1;
    localparam logic [1:0] ACT_SET       = 2'd2;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_STEP_SIZE = 2'd0;
    localparam logic [1:0] REG_BAND_LOCK = 2'd1;
    localparam logic [1:0] REG_REVERSE   = 2'd2;

    typedef struct packed {
        t_step step_size;
        logic  band_lock;
        logic  reverse_mode;
    } t_cfg;

endpackage

`default_nettype wire

@@ hw/rtl/vfs_cfg.sv @@
// ----------------------------------------------------------------------------
// VFO frequency stepper configuration registers
// APB-style register file holding step size, band lock and reverse mode.
// ----------------------------------------------------------------------------
`default_nettype none

module vfs_cfg
    import vfs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_step r_step_size;
    logic  r_band_lock;
    logic  r_reverse_mode;
    logic  w_write;
    logic [1:0] w_index;

    assign pready  = 1'b1;
    assign w_write = psel & penable & pwrite;
    assign w_index = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size    <= STEP_RESET;
            r_band_lock    <= 1'b0;
            r_reverse_mode <= 1'b0;
        end else if (w_write) begin
            case (w_index)
                REG_STEP_SIZE: begin
                    r_step_size <= pwdata[STEP_W-1:0];
                end
                REG_BAND_LOCK: begin
                    r_band_lock <= pwdata[0];
                end
                REG_REVERSE: begin
                    r_reverse_mode <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_index)
            REG_STEP_SIZE: prdata = {{(32-STEP_W){1'b0}}, r_step_size};
            REG_BAND_LOCK: prdata = {31'd0, r_band_lock};
            REG_REVERSE:   prdata = {31'd0, r_reverse_mode};
            default:       prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{step_size: r_step_size, band_lock: r_band_lock,
                     reverse_mode: r_reverse_mode};

endmodule

`default_nettype wire

@@ hw/rtl/vfs_calc.sv @@
// ----------------------------------------------------------------------------
// VFO frequency stepper next-state logic
// Computes the new receive and transmit frequencies of one dial.
// ----------------------------------------------------------------------------
`default_nettype none

module vfs_calc
    import vfs_pkg::*;
(
    input  wire t_cfg        i_cfg,
    input  wire logic [1:0]  i_action,
    input  wire t_freq       i_entry_freq,
    input  wire t_freq       i_rx_cur,
    input  wire t_freq       i_tx_cur,
    output t_freq            o_rx_next,
    output t_freq            o_tx_next,
    output logic             o_accepted
);

    t_freq             w_base;
    logic [SUM_W-1:0]  w_sum;
    logic [SUM_W-1:0]  w_up_val;
    t_freq             w_step27;
    t_freq             w_diff;
    t_freq             w_up_freq;
    t_freq             w_down_freq;
    logic              w_set_ok;

    // Reverse mode steps the transmit side, otherwise both sides from the receive side.
    assign w_base   = i_cfg.reverse_mode ? i_tx_cur : i_rx_cur;
    assign w_sum    = {1'b0, w_base} + {{(SUM_W-STEP_W){1'b0}}, i_cfg.step_size};
    assign w_step27 = {{(FREQ_W-STEP_W){1'b0}}, i_cfg.step_size};
    assign w_diff   = (w_base > w_step27) ? (w_base - w_step27) : '0;

    always_comb begin
        if (i_cfg.band_lock) begin
            if (w_sum > {1'b0, BAND_A_HI} && w_sum < {1'b0, BAND_B_LO}) begin
                w_up_val = {1'b0, BAND_B_LO};
            end else if (w_sum > {1'b0, BAND_B_HI} && w_sum < {1'b0, BAND_C_LO}) begin
                w_up_val = {1'b0, BAND_C_LO};
            end else if (w_sum > {1'b0, BAND_C_HI}) begin
                w_up_val = {1'b0, BAND_A_LO};
            end else begin
                w_up_val = w_sum;
            end
        end else if (w_sum > {1'b0, HIGH_LIMIT}) begin
            w_up_val = {1'b0, HIGH_LIMIT};
        end else begin
            w_up_val = w_sum;
        end
    end

    assign w_up_freq = w_up_val[FREQ_W-1:0];

    always_comb begin
        if (i_cfg.band_lock) begin
            if (w_diff < BAND_A_LO) begin
                w_down_freq = BAND_C_HI;
            end else if (w_diff > BAND_A_HI && w_diff < BAND_B_LO) begin
                w_down_freq = BAND_A_HI;
            end else if (w_diff > BAND_B_HI && w_diff < BAND_C_LO) begin
                w_down_freq = BAND_B_HI;
            end else begin
                w_down_freq = w_diff;
            end
        end else if (w_diff < LOW_LIMIT) begin
            w_down_freq = LOW_LIMIT;
        end else begin
            w_down_freq = w_diff;
        end
    end

    always_comb begin
        if (i_cfg.band_lock) begin
            w_set_ok = (i_entry_freq >= BAND_A_LO && i_entry_freq <= BAND_A_HI) ||
                       (i_entry_freq >= BAND_B_LO && i_entry_freq <= BAND_B_HI) ||
                       (i_entry_freq >= BAND_C_LO && i_entry_freq <= BAND_C_HI);
        end else begin
            w_set_ok = (i_entry_freq >= LOW_LIMIT) && (i_entry_freq <= HIGH_LIMIT);
        end
    end

    always_comb begin
        o_rx_next  = i_rx_cur;
        o_tx_next  = i_tx_cur;
        o_accepted = 1'b0;
        case (i_action)
            ACT_STEP_UP: begin
                o_tx_next  = w_up_freq;
                o_accepted = 1'b1;
                if (!i_cfg.reverse_mode) begin
                    o_rx_next = w_up_freq;
                end
            end
            ACT_STEP_DOWN: begin
                o_tx_next  = w_down_freq;
                o_accepted = 1'b1;
                if (!i_cfg.reverse_mode) begin
                    o_rx_next = w_down_freq;
                end
            end
            ACT_SET: begin
                if (w_set_ok) begin
                    o_tx_next  = i_entry_freq;
                    o_accepted = 1'b1;
                    if (!i_cfg.reverse_mode) begin
                        o_rx_next = i_entry_freq;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/vfo_frequency_stepper_top.sv @@
// ----------------------------------------------------------------------------
// VFO frequency stepper
// Two-dial receive/transmit frequency keeper with stepping and direct entry.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle on the input channel while
// its input does not stall, and returns exactly one result transaction for
// each. An accepted item waits in the input register; the clock edge at which
// the result register is free computes the new frequencies, writes them back
// to the dial store and loads the result register. While the output does not
// stall, the sustained rate is one item per cycle, set by the single add, clamp and
// compare stage between those two registers. The dial store is updated at
// the same edge that loads the result, so an item may follow an item on the
// same dial in the very next cycle. The input stalls only when the input
// register holds an item and the result register holds a transaction that
// is not taken in this cycle, so the block holds at most two transactions.
// Frequencies are in units of 10 Hz; after
// reset dial 0 holds 43002500 and dial 1 holds 43502500 on both sides. The
// registers sit at byte addresses 0 (step size, 24 bits, reset 1250),
// 4 (band lock) and 8 (reverse mode); the user must see that they are
// written only while the block is idle, as the block does not enforce it.
`default_nettype none

`include "vfo_frequency_stepper_top_defines.svh"

module vfo_frequency_stepper_top
    import vfs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic        i_dial,
    input  wire logic [26:0] i_entry_freq,
    // Output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [26:0] o_rx_freq,
    output logic      [26:0] o_tx_freq,
    output logic      [26:0] o_shown_freq,
    output logic             o_accepted
);

    t_cfg       w_cfg;

    // Input register: holds one accepted transaction until it is computed.
    logic       r_in_valid;
    logic [1:0] r_in_action;
    logic       r_in_dial;
    t_freq      r_in_entry;

    // Dial store: one receive and one transmit frequency per dial.
    t_freq      r_rx_store [2];
    t_freq      r_tx_store [2];

    // Result register.
    logic       r_out_valid;
    t_freq      r_out_rx;
    t_freq      r_out_tx;
    t_freq      r_out_shown;
    logic       r_out_accepted;

    logic       w_out_free;
    logic       w_fire;
    logic       w_in_take;
    t_freq      n_rx;
    t_freq      n_tx;
    logic       n_accepted;

    vfs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The held item moves on when the result register is empty or its
    // current transaction leaves in this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_action <= i_action;
            r_in_dial   <= i_dial;
            r_in_entry  <= i_entry_freq;
        end
    end

    vfs_calc u_calc (
        .i_cfg        (w_cfg),
        .i_action     (r_in_action),
        .i_entry_freq (r_in_entry),
        .i_rx_cur     (r_rx_store[r_in_dial]),
        .i_tx_cur     (r_tx_store[r_in_dial]),
        .o_rx_next    (n_rx),
        .o_tx_next    (n_tx),
        .o_accepted   (n_accepted)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_store[0] <= DIAL0_RESET;
            r_rx_store[1] <= DIAL1_RESET;
            r_tx_store[0] <= DIAL0_RESET;
            r_tx_store[1] <= DIAL1_RESET;
        end else if (w_fire) begin
            r_rx_store[r_in_dial] <= n_rx;
            r_tx_store[r_in_dial] <= n_tx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // The shown frequency follows the side that steps act on.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_rx       <= n_rx;
            r_out_tx       <= n_tx;
            r_out_shown    <= w_cfg.reverse_mode ? n_tx : n_rx;
            r_out_accepted <= n_accepted;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_rx_freq    = r_out_rx;
    assign o_tx_freq    = r_out_tx;
    assign o_shown_freq = r_out_shown;
    assign o_accepted   = r_out_accepted;

    // Stored frequencies never leave the tunable range: sets are range
    // checked, and steps clamp, snap or wrap.
    `VFS_ASSERT_NOW(a_store_in_range, i_clk, i_rst_n, 1'b1, (r_rx_store[0] <= HIGH_LIMIT) && (r_rx_store[1] <= HIGH_LIMIT) && (r_tx_store[0] <= HIGH_LIMIT) && (r_tx_store[1] <= HIGH_LIMIT))

    // Outside reverse mode a step leaves receive and transmit equal.
    `VFS_ASSERT_NEXT(a_step_copies_tx, i_clk, i_rst_n, w_fire && !w_cfg.reverse_mode && (r_in_action == ACT_STEP_UP || r_in_action == ACT_STEP_DOWN), (o_rx_freq == o_tx_freq) && o_accepted)

    // Every computed item shows up in the result register.
    `VFS_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, w_fire, o_out_valid)

endmodule

`default_nettype wire

@@ dv/vfo_frequency_stepper_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// VFO frequency stepper testbench
// Drives step, direct-set and unused-code transactions into the stepper,
// predicts every dial readout from its own copy of the dial stores and
// registers, and compares each result transaction as it leaves the block.
// ----------------------------------------------------------------------------

module vfo_frequency_stepper_top_tb;
    import vfs_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 120;
    localparam int PRESSURE_ITEMS = 40;
    localparam int RANDOM_PHASES  = 8;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int REPORT_LIMIT   = 10;

    // The fourth action code is not decoded by the block; it must leave the
    // dial untouched and report it with accepted low.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] action;
        logic       dial;
        t_freq      entry;
    } t_dial_cmd;

    typedef struct packed {
        t_freq rx;
        t_freq tx;
        t_freq shown;
        logic  accepted;
    } t_readout;

    // ------------------------------------------------------------------------
    // Clock, reset and every block input, known from time zero.
    // ------------------------------------------------------------------------
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [3:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_action     = ACT_STEP_UP;
    logic        i_dial       = 1'b0;
    logic [26:0] i_entry_freq = '0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [26:0] o_rx_freq;
    logic [26:0] o_tx_freq;
    logic [26:0] o_shown_freq;
    logic        o_accepted;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    vfo_frequency_stepper_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_dial       (i_dial),
        .i_entry_freq (i_entry_freq),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_rx_freq    (o_rx_freq),
        .o_tx_freq    (o_tx_freq),
        .o_shown_freq (o_shown_freq),
        .o_accepted   (o_accepted)
    );

    // ------------------------------------------------------------------------
    // Dial predictor. It holds its own copy of both dial stores and of the
    // three registers, starting from the reset values of the block.
    // ------------------------------------------------------------------------
    t_freq rx_dial [2]  = '{DIAL0_RESET, DIAL1_RESET};
    t_freq tx_dial [2]  = '{DIAL0_RESET, DIAL1_RESET};
    t_step cfg_step     = STEP_RESET;
    logic  cfg_lock     = 1'b0;
    logic  cfg_reverse  = 1'b0;

    // Readouts predicted for accepted transactions, oldest first.
    t_readout pending_readouts [$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;

    // One step of a frequency. The sum is kept one bit wider than a frequency
    // so that the largest step from the top of the range is not truncated
    // before the clamp or the wrap looks at it.
    function automatic t_freq stepped_freq(t_freq f, logic up);
        logic [SUM_W-1:0] v;
        if (up) begin
            v = f + cfg_step;
            if (cfg_lock) begin
                // Gaps snap upward to the next band; past the top band the
                // dial wraps to the bottom of the lowest one. Anything below
                // the lowest band is left where it lands.
                if (v > BAND_A_HI && v < BAND_B_LO) v = BAND_B_LO;
                if (v > BAND_B_HI && v < BAND_C_LO) v = BAND_C_LO;
                if (v > BAND_C_HI) v = BAND_A_LO;
            end else if (v > HIGH_LIMIT) begin
                v = HIGH_LIMIT;
            end
        end else begin
            // A step larger than the frequency saturates at zero.
            v = (f > cfg_step) ? f - cfg_step : '0;
            if (cfg_lock) begin
                if (v < BAND_A_LO) v = BAND_C_HI;
                if (v > BAND_A_HI && v < BAND_B_LO) v = BAND_A_HI;
                if (v > BAND_B_HI && v < BAND_C_LO) v = BAND_B_HI;
            end else if (v < LOW_LIMIT) begin
                v = LOW_LIMIT;
            end
        end
        return v[FREQ_W-1:0];
    endfunction

    function automatic logic entry_in_band(t_freq f);
        if (!cfg_lock)
            return f >= LOW_LIMIT && f <= HIGH_LIMIT;
        return (f >= BAND_A_LO && f <= BAND_A_HI) ||
               (f >= BAND_B_LO && f <= BAND_B_HI) ||
               (f >= BAND_C_LO && f <= BAND_C_HI);
    endfunction

    // Applies one accepted transaction to the predicted dials and returns
    // the readout the block must produce for it.
    function automatic t_readout apply_command(t_dial_cmd cmd);
        t_readout r;
        logic     ok;
        ok = 1'b0;
        case (cmd.action)
            ACT_STEP_UP, ACT_STEP_DOWN: begin
                if (!cfg_reverse) begin
                    rx_dial[cmd.dial] = stepped_freq(rx_dial[cmd.dial],
                                                     cmd.action == ACT_STEP_UP);
                    tx_dial[cmd.dial] = rx_dial[cmd.dial];
                end else begin
                    tx_dial[cmd.dial] = stepped_freq(tx_dial[cmd.dial],
                                                     cmd.action == ACT_STEP_UP);
                end
                ok = 1'b1;
            end
            ACT_SET: begin
                if (entry_in_band(cmd.entry)) begin
                    if (!cfg_reverse) rx_dial[cmd.dial] = cmd.entry;
                    tx_dial[cmd.dial] = cmd.entry;
                    ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.rx       = rx_dial[cmd.dial];
        r.tx       = tx_dial[cmd.dial];
        r.shown    = cfg_reverse ? tx_dial[cmd.dial] : rx_dial[cmd.dial];
        r.accepted = ok;
        return r;
    endfunction

    function automatic void report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------------
    // Result checker. Every result transaction taken at a clock edge is
    // compared with the oldest predicted readout. Values are read right at
    // the edge, before any nonblocking update of that edge lands.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_readouts
        t_readout got;
        t_readout want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            got = {o_rx_freq, o_tx_freq, o_shown_freq, o_accepted};
            if (pending_readouts.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding: rx %0d tx %0d",
                                          got.rx, got.tx));
            end else begin
                want = pending_readouts.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "rx %0d/%0d tx %0d/%0d shown %0d/%0d accepted %0b/%0b (exp/act)",
                        want.rx, got.rx, want.tx, got.tx, want.shown, got.shown,
                        want.accepted, got.accepted));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. It stalls on a repeating pattern, redrawn whenever stall_phase
    // wraps to zero: sometimes never, sometimes lightly, sometimes half the time.
    // A test can request one long hold-off, which this process counts out
    // itself while the sender keeps offering transactions.
    // ------------------------------------------------------------------------
    logic [15:0] stall_pattern = '0;
    int          stall_phase   = 0;
    int          hold_left     = 0;
    bit          hold_request  = 1'b0;

    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
        end
        if (stall_phase == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pattern = '0;
                1: stall_pattern = 16'($urandom & $urandom & $urandom);
                2: stall_pattern = 16'($urandom);
                default: stall_pattern = 16'(16'h5555 << $urandom_range(0, 1));
            endcase
        end
        stall_phase = (stall_phase + 1) % 64;
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= stall_pattern[stall_phase % 16];
        end
    end

    // A stuck handshake ends the run here rather than hanging it.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d readouts outstanding",
                     cycle_count, pending_readouts.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side. All tasks are entered just after a rising edge and drive
    // with nonblocking assignments, so each signal gets one update per step.
    // ------------------------------------------------------------------------

    // Offers one transaction and holds it until the block takes it; the
    // readout is predicted at the edge of acceptance. Valid stays high on
    // return so that a following transaction goes out back to back.
    task automatic send_item(input t_dial_cmd cmd);
        i_in_valid   <= 1'b1;
        i_action     <= cmd.action;
        i_dial       <= cmd.dial;
        i_entry_freq <= cmd.entry;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_readouts.push_back(apply_command(cmd));
    endtask

    // Gap on the input channel; the payload carries junk while valid is low.
    task automatic idle_input(input int cycles);
        if (cycles != 0) begin
            i_in_valid   <= 1'b0;
            i_action     <= 2'($urandom);
            i_dial       <= 1'($urandom);
            i_entry_freq <= 27'($urandom);
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Waits until every predicted readout has come back, then lets the
    // pipeline run empty before it returns.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pending_readouts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB access: setup cycle, then access cycle. pready is tied high, so
    // the access completes at the edge that ends the access cycle, where read data is taken.
    task automatic apb_access(input logic wr, input logic [1:0] reg_index,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
    endtask

    // Writes all three registers once the block is idle and reads each back.
    task automatic configure(input t_step step, input logic lock, input logic rev);
        logic [1:0]  reg_index [3];
        logic [31:0] value     [3];
        logic [31:0] mask      [3];
        logic [31:0] rdata;
        settle_block();
        reg_index[0] = REG_STEP_SIZE;
        reg_index[1] = REG_BAND_LOCK;
        reg_index[2] = REG_REVERSE;
        value[0]     = {{(32 - STEP_W){1'b0}}, step};
        value[1]     = {31'd0, lock};
        value[2]     = {31'd0, rev};
        mask[0]      = {{(32 - STEP_W){1'b0}}, {STEP_W{1'b1}}};
        mask[1]      = 32'd1;
        mask[2]      = 32'd1;
        for (int i = 0; i < 3; i++) begin
            apb_access(1'b1, reg_index[i], value[i], rdata);
            apb_access(1'b0, reg_index[i], '0, rdata);
            if ((rdata & mask[i]) !== value[i])
                report_mismatch($sformatf("register %0d read back %0h, wrote %0h",
                                          reg_index[i], rdata & mask[i], value[i]));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_step    = step;
        cfg_lock    = lock;
        cfg_reverse = rev;
    endtask

    // Random transaction, weighted toward steps. Half of the direct sets land on
    // or next to a band or range edge so that both outcomes show up often.
    function automatic t_dial_cmd random_command();
        t_dial_cmd cmd;
        int        pick;
        int        base;
        pick      = $urandom_range(0, 99);
        cmd.dial  = 1'($urandom_range(0, 1));
        cmd.entry = t_freq'($urandom);
        if (pick < 38) begin
            cmd.action = ACT_STEP_UP;
        end else if (pick < 74) begin
            cmd.action = ACT_STEP_DOWN;
        end else if (pick < 95) begin
            cmd.action = ACT_SET;
            case ($urandom_range(0, 3))
                0, 1: begin
                    case ($urandom_range(0, 7))
                        0: base = LOW_LIMIT;
                        1: base = HIGH_LIMIT;
                        2: base = BAND_A_LO;
                        3: base = BAND_A_HI;
                        4: base = BAND_B_LO;
                        5: base = BAND_B_HI;
                        6: base = BAND_C_LO;
                        default: base = BAND_C_HI;
                    endcase
                    cmd.entry = t_freq'(base + $urandom_range(0, 4) - 2);
                end
                2: cmd.entry = t_freq'($urandom_range(0, HIGH_LIMIT + 1000));
                default: ;
            endcase
        end else begin
            cmd.action = ACT_UNUSED;
        end
        return cmd;
    endfunction

    // Random transactions in bursts of random length; a zero gap between
    // bursts keeps the channel busy for long stretches.
    task automatic run_random_items(input int count);
        int burst_left;
        burst_left = 0;
        repeat (count) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                idle_input($urandom_range(0, 6));
            end
            send_item(random_command());
            burst_left--;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // The unused action code reports the reset frequencies of each dial and
    // is never accepted; the entry field is ignored.
    task automatic test_reset_readout();
        send_item(t_dial_cmd'{ACT_UNUSED, 1'b0, '1});
        send_item(t_dial_cmd'{ACT_UNUSED, 1'b1, '0});
    endtask

    // Unlocked range with the largest step: direct sets outside and on
    // the range edges, a step down that saturates at zero before the low
    // clamp, and a step up that clamps at the top.
    task automatic test_unlocked_limits();
        configure('1, 1'b0, 1'b0);
        send_item(t_dial_cmd'{ACT_SET,       1'b0, '0});
        send_item(t_dial_cmd'{ACT_SET,       1'b0, LOW_LIMIT});
        send_item(t_dial_cmd'{ACT_STEP_DOWN, 1'b0, '1});
        send_item(t_dial_cmd'{ACT_SET,       1'b1, HIGH_LIMIT + 27'd1});
        send_item(t_dial_cmd'{ACT_SET,       1'b1, HIGH_LIMIT});
        send_item(t_dial_cmd'{ACT_STEP_UP,   1'b1, '0});
    endtask

    // Band lock: snapping out of both gaps in either direction, wrap at both
    // ends, a dial left below the lowest band, a zero step, set edges, and a
    // step down that saturates at zero before wrapping.
    task automatic test_band_lock();
        configure(24'd100, 1'b0, 1'b0);
        send_item(t_dial_cmd'{ACT_SET,       1'b0, 27'd2000000});
        send_item(t_dial_cmd'{ACT_SET,       1'b1, 27'd14000000});
        // A zero step still snaps a dial that sits in a gap.
        configure('0, 1'b1, 1'b0);
        send_item(t_dial_cmd'{ACT_STEP_UP,   1'b1, '0});
        configure(24'd100, 1'b1, 1'b0);
        send_item(t_dial_cmd'{ACT_STEP_UP,   1'b0, '0});
        send_item(t_dial_cmd'{ACT_STEP_DOWN, 1'b0, '0});
        send_item(t_dial_cmd'{ACT_STEP_UP,   1'b0, '0});
        send_item(t_dial_cmd'{ACT_SET,       1'b0, BAND_A_HI});
        send_item(t_dial_cmd'{ACT_STEP_UP,   1'b0, '0});
        send_item(t_dial_cmd'{ACT_STEP_DOWN, 1'b0, '0});
        send_item(t_dial_cmd'{ACT_SET,       1'b1, BAND_B_HI});
        send_item(t_dial_cmd'{ACT_STEP_UP,   1'b1, '0});
        send_item(t_dial_cmd'{ACT_STEP_DOWN, 1'b1, '0});
        send_item(t_dial_cmd'{ACT_SET,       1'b0, BAND_A_LO - 27'd1});
        send_item(t_dial_cmd'{ACT_SET,       1'b0, BAND_C_HI + 27'd1});
        configure('1, 1'b1, 1'b0);
        send_item(t_dial_cmd'{ACT_STEP_DOWN, 1'b0, '0});
    endtask

    // Reverse mode: steps and sets move only the transmit side, and the
    // shown frequency follows transmit.
    task automatic test_reverse_mode();
        configure(STEP_RESET, 1'b0, 1'b1);
        send_item(t_dial_cmd'{ACT_STEP_UP,   1'b0, '0});
        send_item(t_dial_cmd'{ACT_SET,       1'b0, LOW_LIMIT});
        send_item(t_dial_cmd'{ACT_STEP_DOWN, 1'b1, '0});
        send_item(t_dial_cmd'{ACT_UNUSED,    1'b0, '0});
    endtask

    // The receiver holds off for a long stretch while transactions are
    // offered back to back, so the block fills and stalls its input.
    task automatic test_backpressure();
        configure(24'd250000, 1'b1, 1'b0);
        hold_request = 1'b1;
        repeat (PRESSURE_ITEMS) send_item(random_command());
    endtask

    // Random traffic in phases, each under its own register setting. The
    // first phases pin the step size to its extremes.
    task automatic test_random_traffic();
        t_step step;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: step = 24'd1;
                1: step = '1;
                2: step = '0;
                default: begin
                    case ($urandom_range(0, 2))
                        0: step = t_step'($urandom_range(1, 5000));
                        1: step = t_step'($urandom_range(100000, 3000000));
                        default: step = t_step'($urandom);
                    endcase
                end
            endcase
            configure(step, (phase == 1) ? 1'b1 : 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            run_random_items($urandom_range(60, 100));
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence: reset once, directed tests, pressure, random traffic, then
    // wait for the last readout and give the verdict.
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_readout();
        test_unlocked_limits();
        test_band_lock();
        test_reverse_mode();
        test_backpressure();
        test_random_traffic();

        settle_block();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
